// File: rtl/core/rgch_pkg.sv
package rgch_pkg;

  // sizes
  localparam int MAX_READ_LENGTH = 256;
  localparam int BIN_DEPTH       = MAX_READ_LENGTH + 1;
  localparam int BIN_ADDR_W      = $clog2(BIN_DEPTH);
  localparam int LEN_W           = $clog2(MAX_READ_LENGTH + 1);
  localparam int COUNT_BITS      = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = FIFO_PTR_W + 1;

  // field widths
  localparam int MODE_W   = 2;
  localparam int QUAL_W   = 8;
  localparam int FLAGS_W  = 16;
  localparam int SEQLEN_W = 16;
  localparam int BASE_W   = 4;
  localparam int BIN_W    = 9;
  localparam int STATUS_W = 3;
  localparam int OUT_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH = 1'd1;
  localparam logic [QUAL_W-1:0]     MIN_QUALITY_RST = 8'd0;
  localparam logic [CFG_DATA_W-1:0] READ_LENGTH_RST = 9'd100;

  // item modes
  localparam logic [MODE_W-1:0] MODE_HEADER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BASE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // base codes
  localparam logic [BASE_W-1:0] BASE_A = 4'd1;
  localparam logic [BASE_W-1:0] BASE_C = 4'd2;
  localparam logic [BASE_W-1:0] BASE_G = 4'd4;
  localparam logic [BASE_W-1:0] BASE_T = 4'd8;
  localparam logic [BASE_W-1:0] BASE_N = 4'd15;

  // unmapped, secondary, qc-fail, duplicate
  localparam logic [FLAGS_W-1:0] FLAG_REJECT_MASK = 16'h0704;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_BASE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADMAP  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BINNED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HADN    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BADBASE = 3'd6;
  localparam logic [STATUS_W-1:0] ST_QUERY   = 3'd7;

  typedef logic [COUNT_BITS-1:0] count_t;

  // item moving from the classify stage to the bin stage
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  bin_upd;
    logic                  query_hit;
    logic [BIN_ADDR_W-1:0] addr;
    logic                  bin_seen;
    count_t                used;
    count_t                had_n;
    count_t                too_short;
    count_t                bad_map;
  } stage_t;

  // finished result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    bin_count;
    logic [OUT_W-1:0]    used_total;
    logic [OUT_W-1:0]    had_n_total;
    logic [OUT_W-1:0]    too_short_total;
    logic [OUT_W-1:0]    bad_mapping_total;
  } result_t;

  // saturating increment
  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage

// File: rtl/core/rgch_if.sv
// input channel
interface rgch_in_if;
  logic                            valid;
  logic                            ready;
  logic [rgch_pkg::MODE_W-1:0]     mode;
  logic [rgch_pkg::QUAL_W-1:0]     map_quality;
  logic [rgch_pkg::FLAGS_W-1:0]    read_flags;
  logic [rgch_pkg::SEQLEN_W-1:0]   sequence_length;
  logic [rgch_pkg::BASE_W-1:0]     base_code;
  logic [rgch_pkg::BIN_W-1:0]      bin_index;

  modport source (output valid, mode, map_quality, read_flags, sequence_length,
                  base_code, bin_index, input ready);
  modport sink   (input valid, mode, map_quality, read_flags, sequence_length,
                  base_code, bin_index, output ready);
endinterface

// result channel
interface rgch_out_if;
  logic                          valid;
  logic                          ready;
  logic [rgch_pkg::STATUS_W-1:0] status;
  logic [rgch_pkg::OUT_W-1:0]    bin_count;
  logic [rgch_pkg::OUT_W-1:0]    used_total;
  logic [rgch_pkg::OUT_W-1:0]    had_n_total;
  logic [rgch_pkg::OUT_W-1:0]    too_short_total;
  logic [rgch_pkg::OUT_W-1:0]    bad_mapping_total;

  modport source (output valid, status, bin_count, used_total, had_n_total,
                  too_short_total, bad_mapping_total, input ready);
  modport sink   (input valid, status, bin_count, used_total, had_n_total,
                  too_short_total, bad_mapping_total, output ready);
endinterface

// File: rtl/core/rgch_ram.sv
module rgch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rgch_out_fifo.sv
module rgch_out_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  rgch_pkg::result_t                   push_data,
  output logic [rgch_pkg::FIFO_CNT_W-1:0]     count,
  rgch_out_if.source                          out
);

  rgch_pkg::result_t                  buf_r [rgch_pkg::FIFO_DEPTH];
  logic [rgch_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rgch_pkg::FIFO_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rgch_pkg::FIFO_CNT_W-1:0]    count_r, count_nxt;
  logic                               pop;
  rgch_pkg::result_t                  head;

  assign pop   = out.valid && out.ready;
  assign count = count_r;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + rgch_pkg::FIFO_CNT_W'(push) - rgch_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  // head of queue drives the channel
  assign head                  = buf_r[rd_ptr_r];
  assign out.valid             = (count_r != '0);
  assign out.status            = head.status;
  assign out.bin_count         = head.bin_count;
  assign out.used_total        = head.used_total;
  assign out.had_n_total       = head.had_n_total;
  assign out.too_short_total   = head.too_short_total;
  assign out.bad_mapping_total = head.bad_mapping_total;

endmodule

// File: rtl/core/read_gc_content_histogram.sv
// GC-content histogram over a stream of sequencing reads.
// in_itf carries items: a read header (mode header), then the read's base codes
// one per item (mode base), or a query for one histogram bin (mode query).
// out_itf returns exactly one result item per input item, in order, with the
// item's status, the queried bin count (zero unless a query) and the four
// saturating read counters as they stand after that item.
// cfg_we/cfg_index/cfg_data write min_quality (index 0) or read_length
// (index 1); write them only while no item is in flight.
// Results leave the bin stage register through the queue. Throughput: one item
// per cycle while in_itf.ready is high. Bins live in a 257 x 32 RAM, read in
// the cycle an item is taken and written back in the next; a query right
// behind a binned read gets the written value through a forwarding register.
// Reset clears the counters, the read state and one valid flag per bin (bins
// read as zero until first written); no clearing pass, items are taken at once.
// A four-entry result queue absorbs receiver stalls; in_itf.ready drops only
// when that queue and the bin stage together hold four items.
module read_gc_content_histogram (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rgch_in_if.sink                              in_itf,
  rgch_out_if.source                           out_itf,
  input  logic                                 cfg_we,
  input  logic [rgch_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgch_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration
  logic [rgch_pkg::QUAL_W-1:0]     min_quality_r;
  logic [rgch_pkg::CFG_DATA_W-1:0] read_length_r;
  logic [rgch_pkg::LEN_W-1:0]      eff_len;

  // read state and counters
  logic                           read_active_r, read_active_nxt;
  logic [rgch_pkg::LEN_W-1:0]     gc_tally_r, gc_tally_nxt;
  logic [rgch_pkg::LEN_W-1:0]     n_tally_r, n_tally_nxt;
  logic [rgch_pkg::LEN_W-1:0]     base_pos_r, base_pos_nxt;
  rgch_pkg::count_t               used_r, used_nxt;
  rgch_pkg::count_t               had_n_r, had_n_nxt;
  rgch_pkg::count_t               short_r, short_nxt;
  rgch_pkg::count_t               badmap_r, badmap_nxt;

  // bin stage
  logic                           acc;
  rgch_pkg::stage_t               stg;
  rgch_pkg::stage_t               b_r;
  logic                           b_valid_r;
  logic [rgch_pkg::BIN_DEPTH-1:0] bin_valid_r;
  logic [rgch_pkg::BIN_ADDR_W-1:0] ram_raddr;
  rgch_pkg::count_t               ram_rdata;
  logic                           ram_we;
  rgch_pkg::count_t               ram_wdata;
  logic                           fwd_en_r;
  logic [rgch_pkg::BIN_ADDR_W-1:0] fwd_addr_r;
  rgch_pkg::count_t               fwd_data_r;
  rgch_pkg::count_t               bin_old;
  rgch_pkg::result_t              res;
  logic [rgch_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [rgch_pkg::FIFO_CNT_W-1:0] in_flight;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_quality_r <= rgch_pkg::MIN_QUALITY_RST;
      read_length_r <= rgch_pkg::READ_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rgch_pkg::CFG_MIN_QUALITY: min_quality_r <= cfg_data[rgch_pkg::QUAL_W-1:0];
        rgch_pkg::CFG_READ_LENGTH: read_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective read length clamped to 1..max
  always_comb begin
    if (read_length_r == '0) begin
      eff_len = rgch_pkg::LEN_W'(1);
    end else if (read_length_r > rgch_pkg::CFG_DATA_W'(rgch_pkg::MAX_READ_LENGTH)) begin
      eff_len = rgch_pkg::LEN_W'(rgch_pkg::MAX_READ_LENGTH);
    end else begin
      eff_len = rgch_pkg::LEN_W'(read_length_r);
    end
  end

  // handshake: room for one more item in bin stage plus queue
  assign in_flight    = fifo_count + rgch_pkg::FIFO_CNT_W'(b_valid_r);
  assign in_itf.ready = (in_flight < rgch_pkg::FIFO_CNT_W'(rgch_pkg::FIFO_DEPTH));
  assign acc          = in_itf.valid && in_itf.ready;

  // classify stage: read state, counters, bin address
  always_comb begin
    logic [rgch_pkg::LEN_W-1:0] pos_inc;
    read_active_nxt = read_active_r;
    gc_tally_nxt    = gc_tally_r;
    n_tally_nxt     = n_tally_r;
    base_pos_nxt    = base_pos_r;
    used_nxt        = used_r;
    had_n_nxt       = had_n_r;
    short_nxt       = short_r;
    badmap_nxt      = badmap_r;
    pos_inc         = base_pos_r + 1'b1;
    stg             = '0;
    stg.status      = rgch_pkg::ST_BASE;
    ram_raddr       = '0;

    case (in_itf.mode)
      rgch_pkg::MODE_HEADER: begin
        read_active_nxt = 1'b0;
        gc_tally_nxt    = '0;
        n_tally_nxt     = '0;
        base_pos_nxt    = '0;
        if (in_itf.map_quality < min_quality_r
            || (in_itf.read_flags & rgch_pkg::FLAG_REJECT_MASK) != '0) begin
          badmap_nxt = rgch_pkg::sat_inc(badmap_r);
          stg.status = rgch_pkg::ST_BADMAP;
        end else if (in_itf.sequence_length < rgch_pkg::SEQLEN_W'(eff_len)) begin
          short_nxt  = rgch_pkg::sat_inc(short_r);
          stg.status = rgch_pkg::ST_SHORT;
        end else begin
          read_active_nxt = 1'b1;
          stg.status      = rgch_pkg::ST_ACCEPT;
        end
      end
      rgch_pkg::MODE_BASE: begin
        if (read_active_r) begin
          if (in_itf.base_code == rgch_pkg::BASE_C || in_itf.base_code == rgch_pkg::BASE_G) begin
            gc_tally_nxt = gc_tally_r + 1'b1;
          end else if (in_itf.base_code == rgch_pkg::BASE_N) begin
            n_tally_nxt = n_tally_r + 1'b1;
          end
          if (in_itf.base_code != rgch_pkg::BASE_C && in_itf.base_code != rgch_pkg::BASE_G
              && in_itf.base_code != rgch_pkg::BASE_N && in_itf.base_code != rgch_pkg::BASE_A
              && in_itf.base_code != rgch_pkg::BASE_T) begin
            // unknown code drops the read
            read_active_nxt = 1'b0;
            stg.status      = rgch_pkg::ST_BADBASE;
          end else begin
            base_pos_nxt = pos_inc;
            if (pos_inc >= eff_len) begin
              read_active_nxt = 1'b0;
              if (n_tally_nxt == '0) begin
                used_nxt    = rgch_pkg::sat_inc(used_r);
                stg.status  = rgch_pkg::ST_BINNED;
                stg.bin_upd = 1'b1;
                ram_raddr   = rgch_pkg::BIN_ADDR_W'(gc_tally_nxt);
              end else begin
                had_n_nxt  = rgch_pkg::sat_inc(had_n_r);
                stg.status = rgch_pkg::ST_HADN;
              end
            end
          end
        end
      end
      rgch_pkg::MODE_QUERY: begin
        stg.status = rgch_pkg::ST_QUERY;
        if (in_itf.bin_index <= rgch_pkg::BIN_W'(rgch_pkg::MAX_READ_LENGTH)) begin
          stg.query_hit = 1'b1;
          ram_raddr     = rgch_pkg::BIN_ADDR_W'(in_itf.bin_index);
        end
      end
      default: ;
    endcase

    stg.addr      = ram_raddr;
    stg.bin_seen  = bin_valid_r[ram_raddr];
    stg.used      = used_nxt;
    stg.had_n     = had_n_nxt;
    stg.too_short = short_nxt;
    stg.bad_map   = badmap_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_active_r <= 1'b0;
      gc_tally_r    <= '0;
      n_tally_r     <= '0;
      base_pos_r    <= '0;
      used_r        <= '0;
      had_n_r       <= '0;
      short_r       <= '0;
      badmap_r      <= '0;
    end else if (acc) begin
      read_active_r <= read_active_nxt;
      gc_tally_r    <= gc_tally_nxt;
      n_tally_r     <= n_tally_nxt;
      base_pos_r    <= base_pos_nxt;
      used_r        <= used_nxt;
      had_n_r       <= had_n_nxt;
      short_r       <= short_nxt;
      badmap_r      <= badmap_nxt;
    end
  end

  // stage register between classify and bin update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_r <= stg;
    end
  end

  // bin memory
  rgch_ram #(
    .WIDTH (rgch_pkg::COUNT_BITS),
    .DEPTH (rgch_pkg::BIN_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_r.addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // bin stage: old value with forwarding, saturating write-back
  always_comb begin
    if (fwd_en_r && fwd_addr_r == b_r.addr) begin
      bin_old = fwd_data_r;
    end else if (b_r.bin_seen) begin
      bin_old = ram_rdata;
    end else begin
      bin_old = '0;
    end
    ram_we    = b_valid_r && b_r.bin_upd;
    ram_wdata = rgch_pkg::sat_inc(bin_old);
  end

  // write forwarding and per-bin valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r    <= 1'b0;
      bin_valid_r <= '0;
    end else begin
      fwd_en_r <= ram_we;
      if (ram_we) begin
        bin_valid_r[b_r.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= b_r.addr;
      fwd_data_r <= ram_wdata;
    end
  end

  // result item
  always_comb begin
    res.status            = b_r.status;
    res.bin_count         = b_r.query_hit ? rgch_pkg::OUT_W'(bin_old) : '0;
    res.used_total        = rgch_pkg::OUT_W'(b_r.used);
    res.had_n_total       = rgch_pkg::OUT_W'(b_r.had_n);
    res.too_short_total   = rgch_pkg::OUT_W'(b_r.too_short);
    res.bad_mapping_total = rgch_pkg::OUT_W'(b_r.bad_map);
  end

  rgch_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_valid_r),
    .push_data (res),
    .count     (fifo_count),
    .out       (out_itf)
  );

  // queue plus bin stage never hold more than the queue depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight <= rgch_pkg::FIFO_CNT_W'(rgch_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // bin memory is written only by a binned read in the bin stage
  a_write_binned: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (b_r.status == rgch_pkg::ST_BINNED))
    else $error("bin write without binned read");

  // accepted header leaves the read active exactly when its status says so
  a_header_state: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_itf.mode == rgch_pkg::MODE_HEADER)
      |=> (read_active_r == (b_r.status == rgch_pkg::ST_ACCEPT)))
    else $error("read state disagrees with header status");

  // base position never passes the longest read
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    base_pos_r <= rgch_pkg::LEN_W'(rgch_pkg::MAX_READ_LENGTH))
    else $error("base position out of range");

  // two binned reads never reach the bin stage back to back
  a_binned_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !ram_we)
    else $error("back to back bin writes");

endmodule

// File: sim/tb_read_gc_content_histogram.sv
module tb_read_gc_content_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  // codes not named in the package
  localparam logic [rgch_pkg::MODE_W-1:0]  MODE_UNUSED    = 2'd3;
  localparam logic [rgch_pkg::BASE_W-1:0]  BASE_BAD       = 4'd3;
  localparam logic [rgch_pkg::FLAGS_W-1:0] FLAG_UNMAPPED  = 16'h0004;
  localparam logic [rgch_pkg::FLAGS_W-1:0] FLAG_SECONDARY = 16'h0100;
  localparam logic [rgch_pkg::FLAGS_W-1:0] FLAG_QC_FAIL   = 16'h0200;
  localparam logic [rgch_pkg::FLAGS_W-1:0] FLAG_DUPLICATE = 16'h0400;
  localparam int QUAL_MAX       = 255;
  localparam int SEQLEN_MAX     = 65535;
  localparam int BIN_INDEX_MAX  = 511;
  localparam int RESULT_LATENCY = 2;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 80;

  typedef struct packed {
    logic [rgch_pkg::MODE_W-1:0]   mode;
    logic [rgch_pkg::QUAL_W-1:0]   qual;
    logic [rgch_pkg::FLAGS_W-1:0]  flags;
    logic [rgch_pkg::SEQLEN_W-1:0] seqlen;
    logic [rgch_pkg::BASE_W-1:0]   code;
    logic [rgch_pkg::BIN_W-1:0]    bin_idx;
  } read_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rgch_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rgch_pkg::CFG_DATA_W-1:0] cfg_data;

  rgch_in_if  in_itf ();
  rgch_out_if out_itf ();

  read_gc_content_histogram dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_itf    (in_itf),
    .out_itf   (out_itf),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // own copy of the histogram state and registers
  rgch_pkg::count_t bin_tally [0:rgch_pkg::MAX_READ_LENGTH] = '{default: '0};
  logic   read_open = 1'b0;
  int     gc_in_read = 0;
  int     n_in_read = 0;
  int     bases_in_read = 0;
  rgch_pkg::count_t used_reads = '0;
  rgch_pkg::count_t n_reads = '0;
  rgch_pkg::count_t short_reads = '0;
  rgch_pkg::count_t badmap_reads = '0;
  logic [rgch_pkg::QUAL_W-1:0]     min_qual = rgch_pkg::MIN_QUALITY_RST;
  logic [rgch_pkg::CFG_DATA_W-1:0] read_len = rgch_pkg::READ_LENGTH_RST;

  rgch_pkg::result_t counter_snapshots [$];
  rgch_pkg::result_t oldest;
  int fail_count = 0;
  int items_offered = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_len = 0;
  int stall_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamped_length();
    if (read_len < 1) return 1;
    if (read_len > rgch_pkg::MAX_READ_LENGTH) return rgch_pkg::MAX_READ_LENGTH;
    return int'(read_len);
  endfunction

  function automatic rgch_pkg::count_t bumped(input rgch_pkg::count_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // advance the histogram by one item and give the result it should produce
  function automatic rgch_pkg::result_t histogram_update(input read_item_t it);
    rgch_pkg::result_t r;
    int eff;
    logic good;
    eff = clamped_length();
    r = '0;
    r.status = rgch_pkg::ST_BASE;
    case (it.mode)
      rgch_pkg::MODE_HEADER: begin
        read_open = 1'b0;
        gc_in_read = 0;
        n_in_read = 0;
        bases_in_read = 0;
        if (it.qual < min_qual || (it.flags & rgch_pkg::FLAG_REJECT_MASK) != '0) begin
          badmap_reads = bumped(badmap_reads);
          r.status = rgch_pkg::ST_BADMAP;
        end else if (int'(it.seqlen) < eff) begin
          short_reads = bumped(short_reads);
          r.status = rgch_pkg::ST_SHORT;
        end else begin
          read_open = 1'b1;
          r.status = rgch_pkg::ST_ACCEPT;
        end
      end
      rgch_pkg::MODE_BASE: begin
        if (read_open) begin
          good = 1'b1;
          if (it.code == rgch_pkg::BASE_C || it.code == rgch_pkg::BASE_G) gc_in_read++;
          else if (it.code == rgch_pkg::BASE_N) n_in_read++;
          else if (it.code != rgch_pkg::BASE_A && it.code != rgch_pkg::BASE_T) good = 1'b0;
          if (!good) begin
            read_open = 1'b0;
            r.status = rgch_pkg::ST_BADBASE;
          end else begin
            bases_in_read++;
            // read finishes once its classified length is reached
            if (bases_in_read >= eff) begin
              read_open = 1'b0;
              if (n_in_read == 0) begin
                bin_tally[gc_in_read] = bumped(bin_tally[gc_in_read]);
                used_reads = bumped(used_reads);
                r.status = rgch_pkg::ST_BINNED;
              end else begin
                n_reads = bumped(n_reads);
                r.status = rgch_pkg::ST_HADN;
              end
            end
          end
        end
      end
      rgch_pkg::MODE_QUERY: begin
        r.status = rgch_pkg::ST_QUERY;
        if (it.bin_idx <= rgch_pkg::MAX_READ_LENGTH) r.bin_count = bin_tally[it.bin_idx];
      end
      default: ;
    endcase
    r.used_total = used_reads;
    r.had_n_total = n_reads;
    r.too_short_total = short_reads;
    r.bad_mapping_total = badmap_reads;
    return r;
  endfunction

  // item builders; fields unused by the mode carry random noise
  function automatic read_item_t noise_item(input logic [rgch_pkg::MODE_W-1:0] mode);
    read_item_t it;
    it.mode = mode;
    it.qual = rgch_pkg::QUAL_W'($urandom);
    it.flags = rgch_pkg::FLAGS_W'($urandom);
    it.seqlen = rgch_pkg::SEQLEN_W'($urandom);
    it.code = rgch_pkg::BASE_W'($urandom);
    it.bin_idx = rgch_pkg::BIN_W'($urandom);
    return it;
  endfunction

  function automatic read_item_t header_item(input int qual, input int flags, input int len);
    read_item_t it;
    it = noise_item(rgch_pkg::MODE_HEADER);
    it.qual = rgch_pkg::QUAL_W'(qual);
    it.flags = rgch_pkg::FLAGS_W'(flags);
    it.seqlen = rgch_pkg::SEQLEN_W'(len);
    return it;
  endfunction

  function automatic read_item_t base_item(input logic [rgch_pkg::BASE_W-1:0] code);
    read_item_t it;
    it = noise_item(rgch_pkg::MODE_BASE);
    it.code = code;
    return it;
  endfunction

  function automatic read_item_t query_item(input int bin_idx);
    read_item_t it;
    it = noise_item(rgch_pkg::MODE_QUERY);
    it.bin_idx = rgch_pkg::BIN_W'(bin_idx);
    return it;
  endfunction

  function automatic logic [rgch_pkg::BASE_W-1:0] random_base();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return rgch_pkg::BASE_N;
    if (roll < 6) return rgch_pkg::BASE_W'($urandom_range(15));
    case ($urandom_range(3))
      0: return rgch_pkg::BASE_A;
      1: return rgch_pkg::BASE_C;
      2: return rgch_pkg::BASE_G;
      default: return rgch_pkg::BASE_T;
    endcase
  endfunction

  // offer one item, with random idle cycles ahead of it, until it is taken
  task automatic offer_item(input read_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_itf.valid = 1'b0;
      @(negedge clk);
    end
    in_itf.valid = 1'b1;
    in_itf.mode = it.mode;
    in_itf.map_quality = it.qual;
    in_itf.read_flags = it.flags;
    in_itf.sequence_length = it.seqlen;
    in_itf.base_code = it.code;
    in_itf.bin_index = it.bin_idx;
    do @(posedge clk); while (!in_itf.ready);
    counter_snapshots.push_back(histogram_update(it));
    items_offered++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk);
    in_itf.valid = 1'b0;
    while (counter_snapshots.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rgch_pkg::CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = rgch_pkg::CFG_DATA_W'(data);
    if (idx == rgch_pkg::CFG_MIN_QUALITY) min_qual = rgch_pkg::QUAL_W'(data);
    else read_len = rgch_pkg::CFG_DATA_W'(data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // quality threshold, each reject flag, short reads, a header cutting a read
  task automatic test_read_filters();
    wait_for_results();
    write_reg(rgch_pkg::CFG_MIN_QUALITY, 20);
    write_reg(rgch_pkg::CFG_READ_LENGTH, 3);
    offer_item(header_item(19, 0, 3));
    offer_item(header_item(QUAL_MAX, FLAG_UNMAPPED, 3));
    offer_item(header_item(QUAL_MAX, FLAG_SECONDARY, 3));
    offer_item(header_item(QUAL_MAX, FLAG_QC_FAIL, 3));
    offer_item(header_item(QUAL_MAX, FLAG_DUPLICATE, 3));
    offer_item(header_item(20, ~int'(rgch_pkg::FLAG_REJECT_MASK), 2));
    offer_item(header_item(20, 0, SEQLEN_MAX));
    offer_item(base_item(rgch_pkg::BASE_C));
    offer_item(header_item(200, 0, 3));
    offer_item(base_item(rgch_pkg::BASE_G));
    offer_item(base_item(rgch_pkg::BASE_C));
    offer_item(base_item(rgch_pkg::BASE_A));
  endtask

  // had-N, bad base codes and bases with no read open
  task automatic test_base_classes();
    offer_item(header_item(100, 0, 3));
    offer_item(base_item(rgch_pkg::BASE_N));
    offer_item(base_item(rgch_pkg::BASE_A));
    offer_item(base_item(rgch_pkg::BASE_T));
    offer_item(header_item(100, 0, 3));
    offer_item(base_item(rgch_pkg::BASE_A));
    offer_item(base_item(BASE_BAD));
    offer_item(base_item(rgch_pkg::BASE_T));
    offer_item(header_item(100, 0, 3));
    offer_item(base_item(rgch_pkg::BASE_T));
    offer_item(base_item(rgch_pkg::BASE_A));
    offer_item(base_item(rgch_pkg::BASE_T));
    offer_item(base_item(rgch_pkg::BASE_G));
  endtask

  // queries in and out of range, and the unused mode
  task automatic test_query_bins();
    offer_item(query_item(0));
    offer_item(query_item(2));
    offer_item(query_item(rgch_pkg::MAX_READ_LENGTH));
    offer_item(query_item(BIN_INDEX_MAX));
    offer_item(noise_item(MODE_UNUSED));
  endtask

  // read length lowered while a read is open
  task automatic test_length_change();
    wait_for_results();
    write_reg(rgch_pkg::CFG_READ_LENGTH, 8);
    offer_item(header_item(50, 0, 8));
    offer_item(base_item(rgch_pkg::BASE_C));
    offer_item(base_item(rgch_pkg::BASE_A));
    offer_item(base_item(rgch_pkg::BASE_G));
    offer_item(base_item(rgch_pkg::BASE_T));
    offer_item(base_item(rgch_pkg::BASE_C));
    wait_for_results();
    write_reg(rgch_pkg::CFG_READ_LENGTH, 3);
    offer_item(base_item(rgch_pkg::BASE_G));
    offer_item(base_item(rgch_pkg::BASE_G));
    offer_item(query_item(4));
  endtask

  // shortest and longest read lengths, highest quality threshold
  task automatic test_length_extremes();
    wait_for_results();
    write_reg(rgch_pkg::CFG_MIN_QUALITY, 0);
    write_reg(rgch_pkg::CFG_READ_LENGTH, 0);
    offer_item(header_item(0, 0, 0));
    offer_item(header_item(0, 0, 1));
    offer_item(base_item(rgch_pkg::BASE_G));
    offer_item(query_item(1));
    wait_for_results();
    write_reg(rgch_pkg::CFG_MIN_QUALITY, QUAL_MAX);
    write_reg(rgch_pkg::CFG_READ_LENGTH, rgch_pkg::MAX_READ_LENGTH);
    offer_item(header_item(QUAL_MAX - 1, 0, SEQLEN_MAX));
    offer_item(header_item(QUAL_MAX, 0, rgch_pkg::MAX_READ_LENGTH - 1));
    offer_item(header_item(QUAL_MAX, 0, rgch_pkg::MAX_READ_LENGTH));
    repeat (rgch_pkg::MAX_READ_LENGTH) offer_item(base_item(rgch_pkg::BASE_G));
    offer_item(query_item(rgch_pkg::MAX_READ_LENGTH));
    wait_for_results();
    write_reg(rgch_pkg::CFG_READ_LENGTH, BIN_INDEX_MAX);
    offer_item(header_item(QUAL_MAX, 0, rgch_pkg::MAX_READ_LENGTH));
    repeat (rgch_pkg::MAX_READ_LENGTH)
      offer_item(base_item(($urandom_range(1) != 0) ? rgch_pkg::BASE_C : rgch_pkg::BASE_T));
    offer_item(query_item($urandom_range(rgch_pkg::MAX_READ_LENGTH)));
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    int saved_tx;
    wait_for_results();
    write_reg(rgch_pkg::CFG_MIN_QUALITY, 0);
    write_reg(rgch_pkg::CFG_READ_LENGTH, 2);
    saved_tx = tx_idle_pct;
    tx_idle_pct = 0;
    rx_hold_len = HOLD_CYCLES;
    repeat (4) begin
      offer_item(header_item(QUAL_MAX, 0, 2));
      offer_item(base_item(rgch_pkg::BASE_C));
      offer_item(base_item(rgch_pkg::BASE_A));
      offer_item(query_item(1));
    end
    wait_for_results();
    tx_idle_pct = saved_tx;
  endtask

  // one read: mostly well formed, sometimes filtered, cut short or overlong
  task automatic offer_random_read();
    int eff;
    int roll;
    int count;
    eff = clamped_length();
    roll = $urandom_range(99);
    if (roll < 80)
      offer_item(header_item($urandom_range(QUAL_MAX, int'(min_qual)),
                             $urandom_range(SEQLEN_MAX) & ~int'(rgch_pkg::FLAG_REJECT_MASK),
                             ($urandom_range(3) == 0) ? $urandom_range(SEQLEN_MAX, eff)
                                                      : eff + $urandom_range(2)));
    else if (roll < 90)
      offer_item(header_item($urandom_range(QUAL_MAX), $urandom_range(SEQLEN_MAX),
                             $urandom_range(SEQLEN_MAX)));
    else
      offer_item(header_item($urandom_range(QUAL_MAX, int'(min_qual)), 0,
                             $urandom_range(eff - 1)));
    count = eff;
    roll = $urandom_range(9);
    if (roll == 0) count = $urandom_range(eff - 1);
    else if (roll == 1) count = eff + $urandom_range(3, 1);
    repeat (count) offer_item(base_item(random_base()));
    roll = $urandom_range(99);
    if (roll < 30)
      offer_item(query_item(($urandom_range(4) == 0) ? $urandom_range(BIN_INDEX_MAX)
                                                     : $urandom_range(eff + 1)));
    else if (roll < 33)
      offer_item(noise_item(MODE_UNUSED));
  endtask

  // random reads under two register settings per idle pattern
  task automatic test_random_reads(input int tx_pct, input int rx_pct, input int count);
    int goal;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (2) begin
      wait_for_results();
      write_reg(rgch_pkg::CFG_MIN_QUALITY, ($urandom_range(1) << rgch_pkg::QUAL_W) |
                                 (($urandom_range(3) == 0) ? $urandom_range(QUAL_MAX)
                                                           : $urandom_range(60)));
      write_reg(rgch_pkg::CFG_READ_LENGTH,
                ($urandom_range(9) == 0) ? $urandom_range(BIN_INDEX_MAX)
                                         : $urandom_range(12, 1));
      goal = items_offered + count / 2;
      while (items_offered < goal) offer_random_read();
    end
  endtask

  // receiver ready, with random idling and the long hold-off on request
  initial begin
    out_itf.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        out_itf.ready = 1'b0;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
      end
      out_itf.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [rgch_pkg::OUT_W-1:0] want,
                             input logic [rgch_pkg::OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_itf.valid && out_itf.ready) begin
      if (counter_snapshots.size() == 0) begin
        $display("%0t: result with no item outstanding, status %0d", $time, out_itf.status);
        fail_count++;
      end else begin
        oldest = counter_snapshots.pop_front();
        check_field("status", rgch_pkg::OUT_W'(oldest.status),
                    rgch_pkg::OUT_W'(out_itf.status));
        check_field("bin_count", oldest.bin_count, out_itf.bin_count);
        check_field("used_total", oldest.used_total, out_itf.used_total);
        check_field("had_n_total", oldest.had_n_total, out_itf.had_n_total);
        check_field("too_short_total", oldest.too_short_total, out_itf.too_short_total);
        check_field("bad_mapping_total", oldest.bad_mapping_total,
                    out_itf.bad_mapping_total);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_itf.valid && in_itf.ready) || (out_itf.valid && out_itf.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // reset, then the tests in turn
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_itf.valid = 1'b0;
    in_itf.mode = rgch_pkg::MODE_HEADER;
    in_itf.map_quality = '0;
    in_itf.read_flags = '0;
    in_itf.sequence_length = '0;
    in_itf.base_code = '0;
    in_itf.bin_index = '0;
    tx_idle_pct = 18;
    rx_idle_pct = 51;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_read_filters();
    test_base_classes();
    test_query_bins();
    test_length_change();
    test_length_extremes();
    test_backpressure();
    test_random_reads(18, 51, 90);
    test_random_reads(51, 18, 90);
    test_random_reads(0, 0, 90);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && counter_snapshots.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
